// ===== rtl/core/srta_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srta_pkg: shared definitions for the aging station table
// Table sizes, field widths, operation and status codes, and the structs
// that carry control and match flags between the table cells and the tree.
// ----------------------------------------------------------------------------
package srta_pkg;

	localparam int DEPTH         = 64;
	localparam int PAYLOAD_WIDTH = 64;

	localparam int ADDR_W    = 48;
	localparam int PAYLOAD_W = 64;
	localparam int TIME_W    = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// output field widths are fixed by the interface
	localparam int STATUS_W  = 2;
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 7;

	// reduction tree: groups of cells summed first, then the group results
	localparam int GRP    = 8;
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
	localparam int GCNT_W = $clog2(GRP + 1);

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_SWEEP  = 1'b1;

	localparam logic [STATUS_W-1:0] STS_UPDATED  = 2'd0;
	localparam logic [STATUS_W-1:0] STS_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STS_SWEPT    = 2'd3;

	localparam int          PADDR_W       = 3;
	localparam logic        REG_MAX_AGE   = 1'b0;
	localparam logic [31:0] MAX_AGE_RESET = 32'd10000;

	typedef struct packed {
		logic eval;
		logic upd_wr;
		logic ins_wr;
		logic sweep;
	} cell_ctrl_t;

	typedef struct packed {
		logic match;
		logic expire;
	} cell_flag_t;

	typedef struct packed {
		logic lvl1;
		logic lvl2;
	} tree_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/srta_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srta_cell: one table slot
// Holds key, payload, write time and expired mark of one entry, compares the
// broadcast request against them and applies the committed write or sweep.
// ----------------------------------------------------------------------------
module srta_cell
	import srta_pkg::*;
(
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic [IDX_W-1:0]         slot,
	input  logic [CNT_W-1:0]         used_count,
	input  logic [ADDR_W-1:0]        addr,
	input  logic [PAYLOAD_WIDTH-1:0] payload,
	input  logic [TIME_W-1:0]        now,
	input  logic [TIME_W-1:0]        max_age,
	output cell_flag_t               flag
);

	logic [ADDR_W-1:0]        key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;
	logic [TIME_W-1:0]        time_q;
	logic                     expired_q;
	cell_flag_t               flag_q;

	logic              live;
	logic [TIME_W-1:0] age;
	logic              ins_sel;
	logic              wr;

	assign live    = CNT_W'(slot) < used_count;
	// age wraps with the millisecond counter
	assign age     = now - time_q;
	assign ins_sel = ctrl.ins_wr && (slot == used_count[IDX_W-1:0]);
	assign wr      = (ctrl.upd_wr && flag_q.match) || ins_sel;

	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			flag_q.match  <= live && (key_q == addr);
			flag_q.expire <= live && !expired_q && (age > max_age);
		end
		if (ins_sel) begin
			key_q <= addr;
		end
		if (wr) begin
			payload_q <= payload;
			time_q    <= now;
			expired_q <= 1'b0;
		end else if (ctrl.sweep && flag_q.expire) begin
			expired_q <= 1'b1;
		end
	end

	assign flag = flag_q;

endmodule
`default_nettype wire

// ===== rtl/core/srta_tree.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srta_tree: registered reduction of the cell flags
// First level folds groups of cells into hit, slot index and expiry count;
// second level folds the groups into the totals for the request.
// ----------------------------------------------------------------------------
module srta_tree
	import srta_pkg::*;
(
	input  logic             clk,
	input  tree_ctrl_t       ctrl,
	input  cell_flag_t       flags [DEPTH],
	output logic             hit,
	output logic [IDX_W-1:0] hit_idx,
	output logic [CNT_W-1:0] exp_cnt
);

	logic              grp_hit_s1 [NGRP];
	logic [IDX_W-1:0]  grp_idx_s1 [NGRP];
	logic [GCNT_W-1:0] grp_cnt_s1 [NGRP];

	logic             hit_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [CNT_W-1:0] cnt_s2;

	logic              grp_hit [NGRP];
	logic [IDX_W-1:0]  grp_idx [NGRP];
	logic [GCNT_W-1:0] grp_cnt [NGRP];

	logic             tot_hit;
	logic [IDX_W-1:0] tot_idx;
	logic [CNT_W-1:0] tot_cnt;

	// live keys are unique, so at most one cell matches and an or picks its slot
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_hit[g] = 1'b0;
			grp_idx[g] = '0;
			grp_cnt[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					if (flags[g * GRP + k].match) begin
						grp_hit[g] = 1'b1;
						grp_idx[g] = grp_idx[g] | IDX_W'(g * GRP + k);
					end
					grp_cnt[g] = grp_cnt[g] + GCNT_W'(flags[g * GRP + k].expire);
				end
			end
		end
	end

	always_comb begin
		tot_hit = 1'b0;
		tot_idx = '0;
		tot_cnt = '0;
		for (int g = 0; g < NGRP; g++) begin
			tot_hit = tot_hit | grp_hit_s1[g];
			tot_idx = tot_idx | grp_idx_s1[g];
			tot_cnt = tot_cnt + CNT_W'(grp_cnt_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.lvl1) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_hit_s1[g] <= grp_hit[g];
				grp_idx_s1[g] <= grp_idx[g];
				grp_cnt_s1[g] <= grp_cnt[g];
			end
		end
		if (ctrl.lvl2) begin
			hit_s2 <= tot_hit;
			idx_s2 <= tot_idx;
			cnt_s2 <= tot_cnt;
		end
	end

	assign hit     = hit_s2;
	assign hit_idx = idx_s2;
	assign exp_cnt = cnt_s2;

endmodule
`default_nettype wire

// ===== rtl/core/scan_result_table_with_aging.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scan_result_table_with_aging: address-keyed station table with aging
// Update requests look up or append an entry (refused when full); sweep requests mark entries
// older than max_age_ms as expired and report how many were newly marked.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_stall    | func, station_address, entry_payload,
//          |                        | now_ms, batch_last
//  out     | out_valid / out_stall  | status, entry_index, entry_count,
//          |                        | newly_expired, batch_done
//  cfg     | apb write/read         | max_age_ms at byte address 0
//
// An accepted request passes through the compare in every cell (S_EVAL),
// the registered reduction tree (S_LVL1, S_LVL2) and the commit (S_DONE),
// which registers the result; in_stall stays high until the block is back
// in idle, where the next request is taken. The commit waits while the
// previous result is still stalled.
// Reset clears the entry count, the control and max_age_ms (to 10000);
// table contents are not cleared.
// ----------------------------------------------------------------------------
module scan_result_table_with_aging
	import srta_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [ADDR_W-1:0]    station_address,
	input  logic [PAYLOAD_W-1:0] entry_payload,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic                 batch_last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [IDX_OUT_W-1:0] entry_index,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [CNT_OUT_W-1:0] newly_expired,
	output logic                 batch_done
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_LVL1 = 3'd2;
	localparam logic [2:0] S_LVL2 = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [TIME_W-1:0] max_age_q;
	logic [CNT_W-1:0]  used_count_q;

	logic                     func_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;
	logic [TIME_W-1:0]        now_q;
	logic                     last_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [IDX_OUT_W-1:0] entry_index_q;
	logic [CNT_OUT_W-1:0] entry_count_q;
	logic [CNT_OUT_W-1:0] newly_expired_q;
	logic                 batch_done_q;

	logic             accept;
	logic             cfg_wr;
	logic             commit;
	logic             full;
	logic             do_upd;
	logic             do_ins;
	logic             do_sweep;
	cell_ctrl_t       cell_ctrl;
	tree_ctrl_t       tree_ctrl;
	cell_flag_t       flags [DEPTH];
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic [CNT_W-1:0] exp_cnt;
	logic [DEPTH-1:0] match_vec;

	logic [STATUS_W-1:0] nxt_status;
	logic [IDX_W-1:0]    nxt_idx;
	logic [CNT_W-1:0]    nxt_count;
	logic [CNT_W-1:0]    nxt_expired;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_AGE);
	assign prdata   = (paddr[2] == REG_MAX_AGE) ? max_age_q : 32'd0;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign commit   = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign full     = (used_count_q == CNT_W'(DEPTH));

	assign do_upd   = commit && (func_q == FUNC_UPDATE) && hit;
	assign do_ins   = commit && (func_q == FUNC_UPDATE) && !hit && !full;
	assign do_sweep = commit && (func_q == FUNC_SWEEP);

	assign cell_ctrl.eval   = (state_q == S_EVAL);
	assign cell_ctrl.upd_wr = do_upd;
	assign cell_ctrl.ins_wr = do_ins;
	assign cell_ctrl.sweep  = do_sweep;
	assign tree_ctrl.lvl1   = (state_q == S_LVL1);
	assign tree_ctrl.lvl2   = (state_q == S_LVL2);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_vec[i] = flags[i].match;
		end
	end

	always_comb begin
		nxt_status  = STS_FULL;
		nxt_idx     = '0;
		nxt_count   = used_count_q;
		nxt_expired = '0;
		if (func_q == FUNC_SWEEP) begin
			nxt_status  = STS_SWEPT;
			nxt_expired = exp_cnt;
		end else if (hit) begin
			nxt_status = STS_UPDATED;
			nxt_idx    = hit_idx;
		end else if (!full) begin
			nxt_status = STS_INSERTED;
			nxt_idx    = used_count_q[IDX_W-1:0];
			nxt_count  = used_count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_age_q    <= MAX_AGE_RESET;
			used_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				max_age_q <= pwdata;
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EVAL;
				S_EVAL: state_q <= S_LVL1;
				S_LVL1: state_q <= S_LVL2;
				S_LVL2: state_q <= S_DONE;
				S_DONE: if (commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (do_ins) begin
				used_count_q <= nxt_count;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			addr_q    <= station_address;
			payload_q <= entry_payload[PAYLOAD_WIDTH-1:0];
			now_q     <= now_ms;
			last_q    <= batch_last;
		end
		if (commit) begin
			status_q        <= nxt_status;
			entry_index_q   <= IDX_OUT_W'(nxt_idx);
			entry_count_q   <= CNT_OUT_W'(nxt_count);
			newly_expired_q <= CNT_OUT_W'(nxt_expired);
			batch_done_q    <= last_q;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		srta_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.slot       (IDX_W'(g)),
			.used_count (used_count_q),
			.addr       (addr_q),
			.payload    (payload_q),
			.now        (now_q),
			.max_age    (max_age_q),
			.flag       (flags[g])
		);
	end

	srta_tree u_tree (
		.clk     (clk),
		.ctrl    (tree_ctrl),
		.flags   (flags),
		.hit     (hit),
		.hit_idx (hit_idx),
		.exp_cnt (exp_cnt)
	);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign entry_index   = entry_index_q;
	assign entry_count   = entry_count_q;
	assign newly_expired = newly_expired_q;
	assign batch_done    = batch_done_q;

`ifndef NO_ASSERTIONS
	// entry count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	// live keys are unique, so the match flags never show two hits
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LVL1) |-> $onehot0(match_vec))
		else $error("more than one cell matched the request");

	// a new result only appears from a commit
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside commit");

	// an accepted request starts the compare in the next cycle
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EVAL))
		else $error("accepted request did not start evaluation");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the aging station table
// Sends update and sweep requests with random gaps and output stalls, keeps
// its own copy of the table to work out every result, and compares results
// in arrival order. The age limit is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_top
	import srta_pkg::*;
();

	localparam int                 POOL_SIZE     = 80;
	localparam int                 HOLD_CYCLES   = 80;
	localparam int                 SETTLE_CYCLES = 8;
	localparam logic [PADDR_W-1:0] MAX_AGE_ADDR  = PADDR_W'(4 * REG_MAX_AGE);

	typedef enum int {
		IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
	} idle_mode_e;

	typedef struct packed {
		logic                 func;
		logic [ADDR_W-1:0]    addr;
		logic [PAYLOAD_W-1:0] payload;
		logic [TIME_W-1:0]    now;
		logic                 last;
	} scan_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [IDX_OUT_W-1:0] index;
		logic [CNT_OUT_W-1:0] count;
		logic [CNT_OUT_W-1:0] expired;
		logic                 done;
	} table_resp_t;

	logic                 clk;
	logic                 arst_n          = 1'b0;
	logic                 psel            = 1'b0;
	logic                 penable         = 1'b0;
	logic                 pwrite          = 1'b0;
	logic [PADDR_W-1:0]   paddr           = '0;
	logic [31:0]          pwdata          = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid        = 1'b0;
	logic                 in_stall;
	logic                 func            = 1'b0;
	logic [ADDR_W-1:0]    station_address = '0;
	logic [PAYLOAD_W-1:0] entry_payload   = '0;
	logic [TIME_W-1:0]    now_ms          = '0;
	logic                 batch_last      = 1'b0;
	logic                 out_valid;
	logic                 out_stall       = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [IDX_OUT_W-1:0] entry_index;
	logic [CNT_OUT_W-1:0] entry_count;
	logic [CNT_OUT_W-1:0] newly_expired;
	logic                 batch_done;

	scan_result_table_with_aging uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.station_address(station_address), .entry_payload(entry_payload),
		.now_ms(now_ms), .batch_last(batch_last),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.entry_index(entry_index), .entry_count(entry_count),
		.newly_expired(newly_expired), .batch_done(batch_done)
	);

	// local copy of the table
	logic [ADDR_W-1:0]    key_copy [DEPTH];
	logic [PAYLOAD_W-1:0] payload_copy [DEPTH];
	logic [TIME_W-1:0]    stamp_copy [DEPTH];
	logic                 expired_copy [DEPTH];
	int unsigned          rows_used   = 0;
	logic [31:0]          age_limit   = MAX_AGE_RESET;

	table_resp_t          pending_outcomes [$];
	logic [ADDR_W-1:0]    key_pool [POOL_SIZE];
	logic [TIME_W-1:0]    clock_ms    = '0;
	idle_mode_e           idle_mode   = IDLE_NONE;
	int unsigned          holds_asked = 0;
	int unsigned          holds_served;
	int unsigned          hold_left;
	int unsigned          mismatches  = 0;
	int unsigned          results_checked = 0;
	int unsigned          n_inserts = 0, n_updates = 0, n_full = 0, n_sweeps = 0;
	int unsigned          n_expired = 0, n_limits = 1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pending_outcomes.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int unsigned sender_gap_pct(idle_mode_e m);
		return (m == IDLE_SENDER) ? 61 : (m == IDLE_BOTH) ? 26 : 0;
	endfunction

	function automatic int unsigned receiver_stall_pct(idle_mode_e m);
		return (m == IDLE_RECEIVER) ? 61 : (m == IDLE_BOTH) ? 26 : 0;
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic scan_req_t make_request(logic f, logic [ADDR_W-1:0] a,
			logic [PAYLOAD_W-1:0] p, logic [TIME_W-1:0] t, logic l);
		scan_req_t r;
		r.func    = f;
		r.addr    = a;
		r.payload = p;
		r.now     = t;
		r.last    = l;
		return r;
	endfunction

	// applies one request to the local table and returns the result it causes
	function automatic table_resp_t predict_table_outcome(scan_req_t r);
		table_resp_t o;
		logic [TIME_W-1:0] age;
		int unsigned n;
		int slot;
		o      = '0;
		o.done = r.last;
		n      = 0;
		slot   = -1;
		if (r.func == FUNC_SWEEP) begin
			for (int i = 0; i < rows_used; i++) begin
				age = r.now - stamp_copy[i];
				if (!expired_copy[i] && age > age_limit) begin
					expired_copy[i] = 1'b1;
					n++;
				end
			end
			o.status  = STS_SWEPT;
			o.count   = CNT_OUT_W'(rows_used);
			o.expired = CNT_OUT_W'(n);
			n_sweeps++;
			n_expired += n;
			return o;
		end
		for (int i = 0; i < rows_used; i++)
			if (slot < 0 && key_copy[i] == r.addr)
				slot = i;
		if (slot < 0 && rows_used < DEPTH) begin
			slot = rows_used;
			key_copy[slot] = r.addr;
			rows_used++;
			o.status = STS_INSERTED;
			n_inserts++;
		end else if (slot >= 0) begin
			o.status = STS_UPDATED;
			n_updates++;
		end else begin
			o.status = STS_FULL;
			o.count  = CNT_OUT_W'(rows_used);
			n_full++;
			return o;
		end
		payload_copy[slot] = r.payload;
		stamp_copy[slot]   = r.now;
		expired_copy[slot] = 1'b0;
		o.index = IDX_OUT_W'(slot);
		o.count = CNT_OUT_W'(rows_used);
		return o;
	endfunction

	// time mostly creeps forward on the scale of the age limit, with jumps
	function automatic scan_req_t random_request(int unsigned key_span,
			int unsigned sweep_pct);
		int unsigned span, pick;
		logic [ADDR_W-1:0] a;
		span = age_limit / 4 + 2;
		pick = $urandom_range(99);
		if (pick < 70)
			clock_ms += $urandom_range(span);
		else if (pick < 88)
			clock_ms += $urandom_range(3 * span, span);
		else if (pick < 94)
			clock_ms = $urandom;
		else
			clock_ms -= $urandom_range(span);
		a = ($urandom_range(99) < 5) ? random_address()
			: key_pool[$urandom_range(key_span - 1)];
		return make_request(($urandom_range(99) < sweep_pct) ? FUNC_SWEEP : FUNC_UPDATE, a,
			PAYLOAD_W'({$urandom, $urandom}), clock_ms, $urandom_range(3) == 0);
	endfunction

	function automatic void note_mismatch(string what, table_resp_t want, table_resp_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s at %0t: expected st %0d idx %0d cnt %0d exp %0d done %0b,",
				" got st %0d idx %0d cnt %0d exp %0d done %0b"},
				what, $time, want.status, want.index, want.count, want.expired, want.done,
				seen.status, seen.index, seen.count, seen.expired, seen.done);
	endfunction

	task automatic offer_request(input scan_req_t r);
		while ($urandom_range(99) < sender_gap_pct(idle_mode)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= r.func;
		station_address <= r.addr;
		entry_payload   <= r.payload;
		now_ms          <= r.now;
		batch_last      <= r.last;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_outcomes.push_back(predict_table_outcome(r));
	endtask

	// block is idle once every result is back and the pipeline has emptied
	task automatic settle_table();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_age(input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MAX_AGE_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		age_limit  = value;
		n_limits++;
	endtask

	task automatic test_directed_cases();
		idle_mode = IDLE_NONE;
		// sweep of an empty table, then the address and time extremes
		offer_request(make_request(FUNC_SWEEP, '1, '1, 32'd0, 1'b1));
		offer_request(make_request(FUNC_UPDATE, '0, '0, 32'd0, 1'b0));
		offer_request(make_request(FUNC_UPDATE, '1, '1, 32'hFFFF_FFFF, 1'b1));
		offer_request(make_request(FUNC_UPDATE, '0, '1, 32'd5, 1'b0));
		offer_request(make_request(FUNC_UPDATE, key_pool[2], 64'h0123_4567_89AB_CDEF,
			32'd100, 1'b0));
		// age exactly at the limit stays, one past it expires
		offer_request(make_request(FUNC_SWEEP, '0, '0, 32'd10005, 1'b0));
		offer_request(make_request(FUNC_SWEEP, '0, '0, 32'd10006, 1'b1));
		offer_request(make_request(FUNC_SWEEP, '0, '0, 32'd10007, 1'b0));
		// rewriting an expired entry clears its mark
		offer_request(make_request(FUNC_UPDATE, '1, 64'hFEDC_BA98_7654_3210, 32'd10006, 1'b1));
		offer_request(make_request(FUNC_SWEEP, random_address(), '1, 32'd20006, 1'b0));
		// ages across the wrap of the millisecond counter
		offer_request(make_request(FUNC_UPDATE, key_pool[3], '1, 32'hFFFF_FFF0, 1'b0));
		offer_request(make_request(FUNC_SWEEP, '0, '0, 32'd5, 1'b1));
		offer_request(make_request(FUNC_UPDATE, key_pool[3], '0, 32'd20, 1'b0));
		offer_request(make_request(FUNC_SWEEP, '1, '1, 32'hFFFF_FFFF, 1'b0));
		clock_ms = 32'd20;
	endtask

	task automatic test_aging_sweeps(input logic [31:0] limit, input int unsigned count,
			input idle_mode_e mode, input int unsigned key_span, input int unsigned sweep_pct);
		settle_table();
		write_max_age(limit);
		idle_mode = mode;
		repeat (count) offer_request(random_request(key_span, sweep_pct));
	endtask

	task automatic test_fill_to_full();
		settle_table();
		write_max_age(32'hFFFF_FFFF);
		idle_mode = IDLE_SENDER;
		for (int k = 0; k < POOL_SIZE && rows_used < DEPTH; k++) begin
			clock_ms += $urandom_range(50);
			offer_request(make_request(FUNC_UPDATE, key_pool[k], PAYLOAD_W'({$urandom, $urandom}),
				clock_ms, rows_used == DEPTH - 1));
		end
		// new keys are refused, known keys still update
		repeat (6) offer_request(make_request(FUNC_UPDATE, random_address(),
			PAYLOAD_W'({$urandom, $urandom}), clock_ms, $urandom_range(1) == 1));
		offer_request(make_request(FUNC_UPDATE, key_pool[0], '1, clock_ms, 1'b1));
		offer_request(make_request(FUNC_SWEEP, '0, '0, clock_ms + 32'hFFFF_FFFF, 1'b0));
	endtask

	task automatic test_output_holdoff();
		settle_table();
		idle_mode = IDLE_NONE;
		holds_asked++;
		repeat (30) offer_request(random_request(POOL_SIZE, 20));
	endtask

	task automatic test_time_wrap();
		clock_ms = 32'hFFFF_FE00;
		test_aging_sweeps(32'd300, 120, IDLE_BOTH, POOL_SIZE, 25);
	endtask

	// receiver side: random stalls, or a long hold-off when one is asked for
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			out_stall    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			holds_served <= holds_asked;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct(idle_mode));
		end
	end

	always @(posedge clk) begin : check_results
		table_resp_t seen;
		table_resp_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen = {status, entry_index, entry_count, newly_expired, batch_done};
			results_checked++;
			if (pending_outcomes.size() == 0) begin
				note_mismatch("unexpected result", '0, seen);
			end else begin
				want = pending_outcomes.pop_front();
				if (seen.status !== want.status || seen.index !== want.index ||
						seen.count !== want.count || seen.expired !== want.expired ||
						seen.done !== want.done)
					note_mismatch("wrong result", want, seen);
			end
		end
	end

	initial begin
		bit fresh;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++) begin
			do begin
				key_pool[k] = random_address();
				fresh = 1'b1;
				for (int j = 0; j < k; j++)
					if (key_pool[j] == key_pool[k])
						fresh = 1'b0;
			end while (!fresh);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_aging_sweeps(32'd0, 200, IDLE_NONE, 40, 15);
		test_fill_to_full();
		test_aging_sweeps(32'd2500, 220, IDLE_RECEIVER, POOL_SIZE, 20);
		test_output_holdoff();
		test_aging_sweeps(32'd0, 150, IDLE_BOTH, POOL_SIZE, 25);
		test_time_wrap();
		test_aging_sweeps(32'd1, 120, IDLE_SENDER, POOL_SIZE, 25);
		test_aging_sweeps(32'hFFFF_FFFF, 120, IDLE_RECEIVER, POOL_SIZE, 20);
		test_aging_sweeps(MAX_AGE_RESET, 200, IDLE_NONE, POOL_SIZE, 15);
		settle_table();

		$display("checked %0d results: %0d inserts, %0d updates, %0d refused as full, %0d sweeps",
			results_checked, n_inserts, n_updates, n_full, n_sweeps);
		$display("sweeps expired %0d entries over %0d age limits, %0d mismatches",
			n_expired, n_limits, mismatches);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
